// File: rtl/sst_pkg.sv
package sst_pkg;

	// Actions carried by a request transaction.
	localparam logic [1:0] ACT_OPEN    = 2'd0;
	localparam logic [1:0] ACT_CLOSE   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP  = 2'd2;
	localparam logic [1:0] ACT_INSTALL = 2'd3;

	// Status codes returned with every response.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] name_key;
		logic [7:0]  entry_kind;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] entry_index;
		logic [5:0] scope_depth;
	} rsp_t;

	// Datapath operations selected by the microcode.
	localparam int OP_W = 4;
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_LATCH     = 4'd1;
	localparam op_t OP_OPEN      = 4'd2;
	localparam op_t OP_CLOSE     = 4'd3;
	localparam op_t OP_LOAD_START = 4'd4;
	localparam op_t OP_INIT_ALL  = 4'd5;
	localparam op_t OP_INIT_SCOPE = 4'd6;
	localparam op_t OP_SCAN_LKP  = 4'd7;
	localparam op_t OP_SCAN_INS  = 4'd8;
	localparam op_t OP_APPEND    = 4'd9;
	localparam op_t OP_EMIT      = 4'd10;

	// Branch conditions.
	localparam int COND_W = 3;
	typedef logic [COND_W-1:0] cond_t;
	localparam cond_t C_ALWAYS    = 3'd0;
	localparam cond_t C_IN_VALID  = 3'd1;
	localparam cond_t C_CAN_CLOSE = 3'd2;
	localparam cond_t C_SCAN_DONE = 3'd3;
	localparam cond_t C_OUT_FREE  = 3'd4;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  dispatch;
		step_t target_t;
		step_t target_f;
	} ctrl_word_t;

	// Datapath status seen by the sequencer.
	typedef struct packed {
		logic       in_valid;
		logic [1:0] action;
		logic       can_close;
		logic       scan_done;
		logic       out_free;
	} seq_flags_t;

endpackage

// File: rtl/scoped_symbol_table.sv
// Block-structured symbol table with a scope stack. Each request transaction
// opens a scope, closes one, looks a name up or installs a name with its
// kind; every request yields exactly one response transaction carrying a
// status, an entry index (0 when there is none) and the nesting level after
// the request. Entry 0 is never used, and the outermost level is 1. Requests
// are handled one at a time by a small microcoded sequencer; a new request is
// taken as soon as the previous response sits in the output register, even if
// it has not yet been collected. An open walks through the latch, open and
// result steps; a close walks through the latch, close, fetch and result
// steps, and a close of the outermost level skips the fetch step. Both are a
// fixed walk through the program. A lookup and an install first set up the
// search and then scan the name memory one entry per cycle, newest first,
// until the search stops; an install then adds an append step before the
// result step. A lookup covers the whole table while an install covers only
// the current scope. The final step also waits for as long as the previous
// response is still held in the output register. There is no clearing pass
// after reset: the search never reaches entries that have not been written.
module scoped_symbol_table
	import sst_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int SCOPE_DEPTH = 32,
	parameter int NAME_BITS   = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Index widths: next_free can reach TABLE_DEPTH itself, addresses cannot.
	localparam int TW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(TABLE_DEPTH);
	// The level runs from 1 to SCOPE_DEPTH; the scope memory is addressed
	// by level minus one.
	localparam int LW = $clog2(SCOPE_DEPTH + 1);
	localparam int SW = $clog2(SCOPE_DEPTH);

	localparam logic [TW-1:0] IDX_ONE  = TW'(1);
	localparam logic [TW-1:0] IDX_FULL = TW'(TABLE_DEPTH);
	localparam logic [LW-1:0] LVL_ONE  = LW'(1);
	localparam logic [LW-1:0] LVL_TWO  = LW'(2);
	localparam logic [LW-1:0] LVL_MAX  = LW'(SCOPE_DEPTH);

	ctrl_word_t cw;
	seq_flags_t flags;

	// Table state.
	logic [TW-1:0] next_free_q;
	logic [LW-1:0] level_q;
	logic [TW-1:0] start_q;     // first entry of the current scope

	// Request being worked on.
	logic [NAME_BITS-1:0] key_q;
	logic [7:0]           kind_q;
	logic [2:0]           status_q;
	logic [TW-1:0]        idx_q;
	logic                 hit_q;

	// Search pointer and the one-deep read pipeline of the name memory.
	logic [TW-1:0]        ptr_q;
	logic [TW-1:0]        floor_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic [NAME_BITS-1:0] name_rd_s1;

	logic [TW-1:0] scope_rd_s1;

	logic [NAME_BITS-1:0] name_mem  [TABLE_DEPTH];
	logic [7:0]           kind_mem  [TABLE_DEPTH];
	logic [TW-1:0]        scope_mem [SCOPE_DEPTH];

	rsp_t rsp_q;
	logic rsp_valid_q;

	sst_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	// Search datapath. Each cycle the entry read in the previous cycle is
	// compared with the key while the next lower entry is read. The search
	// ends on the first match, or once every entry down to and including the
	// floor has been compared without one.
	logic          is_scan;
	logic          scan_more;
	logic          scan_match;
	logic          scan_issue;
	logic [TW-1:0] ptr_dec;
	logic          can_write;
	logic          out_free;
	logic [TW-1:0] lvl_as_idx_dummy;
	logic [LW-1:0] level_dec2;

	assign is_scan    = (cw.op == OP_SCAN_LKP) || (cw.op == OP_SCAN_INS);
	assign scan_more  = ptr_q > floor_q;
	assign scan_match = rd_vld_s1 && (name_rd_s1 == key_q);
	assign scan_issue = is_scan && !scan_match && scan_more;
	assign ptr_dec    = ptr_q - IDX_ONE;
	assign level_dec2 = level_q - LVL_TWO;
	assign lvl_as_idx_dummy = next_free_q;
	assign can_write  = (cw.op == OP_APPEND) && !hit_q && (lvl_as_idx_dummy != IDX_FULL);
	assign out_free   = !rsp_valid_q || rsp_ready;

	assign flags.in_valid  = req_valid;
	assign flags.action    = req.action;
	assign flags.can_close = level_q > LVL_ONE;
	assign flags.scan_done = scan_match || !scan_more;
	assign flags.out_free  = out_free;

	assign req_ready = (cw.op == OP_LATCH);

	// Table and scope bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= IDX_ONE;
			level_q     <= LVL_ONE;
			start_q     <= IDX_ONE;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			case (cw.op)
				OP_OPEN: begin
					if (level_q != LVL_MAX) begin
						level_q <= level_q + LVL_ONE;
						start_q <= next_free_q;
					end
				end
				OP_CLOSE: begin
					if (level_q > LVL_ONE) begin
						next_free_q <= start_q;
						level_q     <= level_q - LVL_ONE;
					end
				end
				OP_LOAD_START: begin
					// Level 1 always starts at entry 1 and is never stored.
					start_q <= (level_q == LVL_ONE) ? IDX_ONE : scope_rd_s1;
				end
				OP_INIT_ALL, OP_INIT_SCOPE: begin
					hit_q     <= 1'b0;
					rd_vld_s1 <= 1'b0;
				end
				OP_SCAN_LKP, OP_SCAN_INS: begin
					if (scan_match) begin
						hit_q <= 1'b1;
					end
					rd_vld_s1 <= scan_issue;
				end
				OP_APPEND: begin
					if (can_write) begin
						next_free_q <= next_free_q + IDX_ONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request payload, result fields and search pointer.
	always_ff @(posedge clk) begin
		case (cw.op)
			OP_LATCH: begin
				if (req_valid) begin
					key_q    <= req.name_key[NAME_BITS-1:0];
					kind_q   <= req.entry_kind;
					status_q <= ST_OK;
					idx_q    <= '0;
				end
			end
			OP_OPEN: begin
				if (level_q == LVL_MAX) begin
					status_q <= ST_FULL;
				end
			end
			OP_CLOSE: begin
				if (level_q <= LVL_ONE) begin
					status_q <= ST_UNDERFLOW;
				end
			end
			OP_INIT_ALL: begin
				ptr_q   <= next_free_q;
				floor_q <= IDX_ONE;
			end
			OP_INIT_SCOPE: begin
				ptr_q   <= next_free_q;
				floor_q <= start_q;
			end
			OP_SCAN_LKP, OP_SCAN_INS: begin
				if (scan_match) begin
					idx_q <= TW'(rd_idx_s1);
					if (cw.op == OP_SCAN_INS) begin
						status_q <= ST_DUPLICATE;
					end
				end else if (!scan_more && cw.op == OP_SCAN_LKP) begin
					status_q <= ST_NOT_FOUND;
				end
				if (scan_issue) begin
					ptr_q     <= ptr_dec;
					rd_idx_s1 <= ptr_dec[AW-1:0];
				end
			end
			OP_APPEND: begin
				if (!hit_q) begin
					if (can_write) begin
						idx_q <= next_free_q;
					end else begin
						status_q <= ST_FULL;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Name and kind memories: one write port for installs, one read port
	// for the search.
	always_ff @(posedge clk) begin
		if (can_write) begin
			name_mem[next_free_q[AW-1:0]] <= key_q;
			kind_mem[next_free_q[AW-1:0]] <= kind_q;
		end
		if (scan_issue) begin
			name_rd_s1 <= name_mem[ptr_dec[AW-1:0]];
		end
	end

	// Scope start memory. An open records where the new level begins; a
	// close reads back the start of the level it returns to.
	always_ff @(posedge clk) begin
		if (cw.op == OP_OPEN && level_q != LVL_MAX) begin
			scope_mem[level_q[SW-1:0]] <= next_free_q;
		end
		if (cw.op == OP_CLOSE) begin
			scope_rd_s1 <= scope_mem[level_dec2[SW-1:0]];
		end
	end

	// Output register: the response waits here while the next request is
	// taken in.
	logic [TW+7:0] idx_ext;
	logic [LW+5:0] lvl_ext;

	assign idx_ext = {8'd0, idx_q};
	assign lvl_ext = {6'd0, level_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cw.op == OP_EMIT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && out_free) begin
			rsp_q.status      <= status_q;
			rsp_q.entry_index <= idx_ext[7:0];
			rsp_q.scope_depth <= lvl_ext[5:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/sst_seq.sv
module sst_seq
	import sst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  seq_flags_t flags,
	output ctrl_word_t cw
);

	localparam step_t S_IDLE     = 4'd0;
	localparam step_t S_OPEN     = 4'd1;
	localparam step_t S_CLOSE    = 4'd2;
	localparam step_t S_LOOKUP   = 4'd3;
	localparam step_t S_INSTALL  = 4'd4;
	localparam step_t S_FETCH    = 4'd5;
	localparam step_t S_SCAN_LKP = 4'd6;
	localparam step_t S_SCAN_INS = 4'd7;
	localparam step_t S_APPEND   = 4'd8;
	localparam step_t S_RESULT   = 4'd9;

	// The program. The idle step dispatches on the action: the four action
	// handlers sit at consecutive steps starting at S_OPEN.
	function automatic ctrl_word_t prog(input step_t s);
		ctrl_word_t w;
		case (s)
			S_IDLE:     w = '{OP_LATCH,      C_IN_VALID,  1'b1, S_OPEN,     S_IDLE};
			S_OPEN:     w = '{OP_OPEN,       C_ALWAYS,    1'b0, S_RESULT,   S_RESULT};
			S_CLOSE:    w = '{OP_CLOSE,      C_CAN_CLOSE, 1'b0, S_FETCH,    S_RESULT};
			S_LOOKUP:   w = '{OP_INIT_ALL,   C_ALWAYS,    1'b0, S_SCAN_LKP, S_SCAN_LKP};
			S_INSTALL:  w = '{OP_INIT_SCOPE, C_ALWAYS,    1'b0, S_SCAN_INS, S_SCAN_INS};
			S_FETCH:    w = '{OP_LOAD_START, C_ALWAYS,    1'b0, S_RESULT,   S_RESULT};
			S_SCAN_LKP: w = '{OP_SCAN_LKP,   C_SCAN_DONE, 1'b0, S_RESULT,   S_SCAN_LKP};
			S_SCAN_INS: w = '{OP_SCAN_INS,   C_SCAN_DONE, 1'b0, S_APPEND,   S_SCAN_INS};
			S_APPEND:   w = '{OP_APPEND,     C_ALWAYS,    1'b0, S_RESULT,   S_RESULT};
			S_RESULT:   w = '{OP_EMIT,       C_OUT_FREE,  1'b0, S_IDLE,     S_RESULT};
			default:    w = '{OP_NONE,       C_ALWAYS,    1'b0, S_IDLE,     S_IDLE};
		endcase
		return w;
	endfunction

	step_t step_q;
	step_t step_next;
	logic  cond_true;

	assign cw = prog(step_q);

	always_comb begin
		case (cw.cond)
			C_ALWAYS:    cond_true = 1'b1;
			C_IN_VALID:  cond_true = flags.in_valid;
			C_CAN_CLOSE: cond_true = flags.can_close;
			C_SCAN_DONE: cond_true = flags.scan_done;
			C_OUT_FREE:  cond_true = flags.out_free;
			default:     cond_true = 1'b1;
		endcase
		if (!cond_true) begin
			step_next = cw.target_f;
		end else if (cw.dispatch) begin
			step_next = cw.target_t + step_t'(flags.action);
		end else begin
			step_next = cw.target_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

endmodule
